// ===== design/lcfd_pkg.sv =====
// Shared types, constants and radix helpers for the laser command frame decoder.
`default_nettype none

package lcfd_pkg;

	localparam int MaxFrameBytes = 12;
	localparam int CountW        = $clog2(MaxFrameBytes + 2);
	localparam int CoordW        = 38;
	localparam int AmountW       = 37;
	localparam int OutDataW      = 160;

	localparam logic [7:0] OpcodeMin   = 8'h80;
	localparam logic [7:0] SignLimit   = 8'h40;
	localparam logic [7:0] DigitMask   = 8'h7F;

	localparam logic [7:0] OpAbsMove   = 8'h88;
	localparam logic [7:0] OpAbsCut    = 8'hA8;
	localparam logic [7:0] OpRelMove   = 8'h89;
	localparam logic [7:0] OpRelCut    = 8'hA9;
	localparam logic [7:0] OpAxisMoveX = 8'h8A;
	localparam logic [7:0] OpAxisMoveY = 8'h8B;
	localparam logic [7:0] OpAxisCutX  = 8'hAA;
	localparam logic [7:0] OpAxisCutY  = 8'hAB;
	localparam logic [7:0] OpPower     = 8'hC6;
	localparam logic [7:0] OpSpeed     = 8'hC9;
	localparam logic [7:0] OpLayer     = 8'hCA;
	localparam logic [7:0] OpLimits    = 8'hE7;

	localparam logic [7:0] SubPow1Min  = 8'h01;
	localparam logic [7:0] SubPow1Max  = 8'h02;
	localparam logic [7:0] SubPow2Min  = 8'h21;
	localparam logic [7:0] SubPow2Max  = 8'h22;
	localparam logic [7:0] SubLPow1Min = 8'h31;
	localparam logic [7:0] SubLPow1Max = 8'h32;
	localparam logic [7:0] SubLPow2Min = 8'h41;
	localparam logic [7:0] SubLPow2Max = 8'h42;
	localparam logic [7:0] SubSpeed    = 8'h02;
	localparam logic [7:0] SubLSpeed   = 8'h04;
	localparam logic [7:0] SubDevices  = 8'h01;
	localparam logic [7:0] SubCurLayer = 8'h02;
	localparam logic [7:0] SubMaxLayer = 8'h22;
	localparam logic [7:0] SubColour   = 8'h06;
	localparam logic [7:0] SubLimMin   = 8'h03;
	localparam logic [7:0] SubLimMax   = 8'h07;

	typedef enum logic [3:0] {
		KIND_EMPTY      = 4'd0,
		KIND_INCOMPLETE = 4'd1,
		KIND_UNKNOWN    = 4'd2,
		KIND_LIMITS     = 4'd3,
		KIND_ABS        = 4'd4,
		KIND_REL        = 4'd5,
		KIND_REL_AXIS   = 4'd6,
		KIND_DEVICES    = 4'd7,
		KIND_COLOUR     = 4'd8,
		KIND_CURLAYER   = 4'd9,
		KIND_MAXLAYER   = 4'd10,
		KIND_POWER      = 4'd11,
		KIND_LAYERPOWER = 4'd12,
		KIND_SPEED      = 4'd13,
		KIND_LAYERSPEED = 4'd14
	} kind_t;

	typedef logic [MaxFrameBytes-1:0][7:0] frame_t;
	typedef logic [0:4][7:0] digits_t;

	typedef struct packed {
		logic              empty;
		logic [CountW-1:0] count;
		frame_t            bytes;
	} snap_t;

	typedef struct packed {
		kind_t               kind;
		logic [2:0]          flags;
		logic [1:0]          laser_number;
		logic [CoordW-1:0]   x_value;
		logic [CoordW-1:0]   y_value;
		logic [7:0]          layer_index;
		logic [AmountW-1:0]  amount;
		logic [7:0]          red;
		logic [7:0]          green;
		logic [7:0]          blue;
		logic                air_blower;
	} result_t;

	function automatic logic [CoordW-1:0] radix_value(digits_t d);
		logic [34:0]       lo;
		logic [CoordW-1:0] hi;
		lo = {d[0][6:0], d[1][6:0], d[2][6:0], d[3][6:0], d[4][6:0]};
		hi = '0;
		for (int i = 0; i < 5; i++) begin
			hi[7 * (5 - i)] = d[i][7];
		end
		return {3'b000, lo} + hi;
	endfunction

	function automatic logic [CoordW-1:0] signed_value(digits_t d, logic short_num);
		logic    neg;
		digits_t t;
		neg = (short_num ? d[3] : d[0]) >= SignLimit;
		for (int i = 0; i < 5; i++) begin
			t[i] = (neg && (!short_num || i >= 3)) ? (d[i] ^ DigitMask) : d[i];
		end
		return neg ? ~radix_value(t) : radix_value(t);
	endfunction

endpackage

`default_nettype wire

// ===== design/lcfd_capture.sv =====
// Frame byte buffer, byte counter and snapshot stage of the frame decoder.
`default_nettype none

module lcfd_capture
	import lcfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       in_empty,
	input  wire logic       take_s1,
	output logic            in_ready,
	output logic            valid_s1,
	output snap_t           snap_s1
);

	logic [CountW-1:0] count_q;
	frame_t            buf_q;
	frame_t            merged;
	logic [CountW-1:0] count_inc;
	logic              accept;
	logic              closing;

	assign in_ready = !valid_s1 || take_s1;
	assign accept   = in_valid && in_ready;
	assign closing  = in_empty || in_last;

	always_comb begin
		for (int i = 0; i < MaxFrameBytes; i++) begin
			merged[i] = (count_q == CountW'(i)) ? in_byte : buf_q[i];
		end
		count_inc = (count_q <= CountW'(MaxFrameBytes)) ? count_q + 1'b1 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= closing ? '0 : count_inc;
			end
			if (accept && closing) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !in_empty) begin
			buf_q <= merged;
		end
		if (accept && closing) begin
			snap_s1.empty <= in_empty;
			snap_s1.count <= in_empty ? '0 : count_inc;
			snap_s1.bytes <= merged;
		end
	end

endmodule

`default_nettype wire

// ===== design/lcfd_decode.sv =====
// Command decode logic and result register of the frame decoder.
`default_nettype none

module lcfd_decode
	import lcfd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  valid_s1,
	input  wire snap_t snap_s1,
	input  wire logic  out_ready,
	output logic       take_s1,
	output logic       out_valid_q,
	output result_t    result_q
);

	result_t           res;
	frame_t            b;
	logic [CountW-1:0] n;
	logic [7:0]        op;
	logic [7:0]        sub;
	logic [CoordW-1:0] step;
	logic [CoordW-1:0] colour;

	assign take_s1 = !out_valid_q || out_ready;

	always_comb begin
		b      = snap_s1.bytes;
		n      = snap_s1.count;
		op     = b[0];
		sub    = (n >= CountW'(2)) ? b[1] : 8'h00;
		step   = signed_value({8'h00, 8'h00, 8'h00, b[1], b[2]}, 1'b1);
		colour = radix_value({b[3], b[4], b[5], b[6], b[7]});
		res    = '0;
		res.kind = KIND_UNKNOWN;
		if (snap_s1.empty) begin
			res.kind = KIND_EMPTY;
		end else if (op < OpcodeMin) begin
			res.kind = KIND_INCOMPLETE;
		end else if (n <= CountW'(MaxFrameBytes)) begin
			case (op)
				OpAbsMove, OpAbsCut: begin
					if (n == CountW'(11)) begin
						res.kind     = KIND_ABS;
						res.flags[0] = (op == OpAbsCut);
						res.x_value  = signed_value({b[1], b[2], b[3], b[4], b[5]}, 1'b0);
						res.y_value  = signed_value({b[6], b[7], b[8], b[9], b[10]}, 1'b0);
					end
				end
				OpRelMove, OpRelCut: begin
					if (n == CountW'(5)) begin
						res.kind     = KIND_REL;
						res.flags[0] = (op == OpRelCut);
						res.x_value  = step;
						res.y_value  = signed_value({8'h00, 8'h00, 8'h00, b[3], b[4]}, 1'b1);
					end
				end
				OpAxisMoveX, OpAxisMoveY, OpAxisCutX, OpAxisCutY: begin
					if (n == CountW'(3)) begin
						res.kind  = KIND_REL_AXIS;
						res.flags = {op[0], 1'b0, op[5]};
						if (op[0]) begin
							res.y_value = step;
						end else begin
							res.x_value = step;
						end
					end
				end
				OpPower: begin
					if (n == CountW'(4) && (sub inside {SubPow1Min, SubPow1Max,
							SubPow2Min, SubPow2Max})) begin
						res.kind         = KIND_POWER;
						res.flags[1]     = sub[1];
						res.laser_number = {1'b0, sub[5]} + 2'd1;
						res.amount       = AmountW'(radix_value({8'h00, 8'h00, 8'h00,
							b[2], b[3]}));
					end else if (n == CountW'(5) && (sub inside {SubLPow1Min,
							SubLPow1Max, SubLPow2Min, SubLPow2Max})) begin
						res.kind         = KIND_LAYERPOWER;
						res.flags[1]     = sub[1];
						res.laser_number = 2'(sub[6:4] - 3'd2);
						res.layer_index  = b[2];
						res.amount       = AmountW'(radix_value({8'h00, 8'h00, 8'h00,
							b[3], b[4]}));
					end
				end
				OpSpeed: begin
					if (n == CountW'(7) && sub == SubSpeed) begin
						res.kind   = KIND_SPEED;
						res.amount = AmountW'(radix_value({b[2], b[3], b[4], b[5], b[6]}));
					end else if (n == CountW'(8) && sub == SubLSpeed) begin
						res.kind        = KIND_LAYERSPEED;
						res.layer_index = b[2];
						res.amount      = AmountW'(colour);
					end
				end
				OpLayer: begin
					if (n == CountW'(3) && sub == SubDevices) begin
						res.kind       = KIND_DEVICES;
						res.amount     = AmountW'(b[2]);
						res.air_blower = b[2][0];
					end else if (n == CountW'(3) && sub == SubCurLayer) begin
						res.kind        = KIND_CURLAYER;
						res.layer_index = b[2];
					end else if (n == CountW'(3) && sub == SubMaxLayer) begin
						res.kind        = KIND_MAXLAYER;
						res.layer_index = b[2];
					end else if (n == CountW'(8) && sub == SubColour) begin
						res.kind        = KIND_COLOUR;
						res.layer_index = b[2];
						res.amount      = AmountW'(colour);
						res.red         = colour[7:0];
						res.green       = colour[15:8];
						res.blue        = colour[23:16];
					end
				end
				OpLimits: begin
					if (n == CountW'(12) && (sub == SubLimMin || sub == SubLimMax)) begin
						res.kind     = KIND_LIMITS;
						res.flags[1] = (sub == SubLimMax);
						res.x_value  = signed_value({b[2], b[3], b[4], b[5], b[6]}, 1'b0);
						res.y_value  = signed_value({b[7], b[8], b[9], b[10], b[11]}, 1'b0);
					end
				end
				default: begin
					res.kind = KIND_UNKNOWN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && valid_s1) begin
			result_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== design/laser_command_frame_decoder.sv =====
// Top level of the laser command frame decoder.
//
//  channel  dir  payload                                       closes on
//  s_axis   in   tdata: cmd_byte; tlast: last_byte;            tlast or tuser[0]
//                tuser: empty_frame
//  m_axis   out  tdata: decoded command result                 one per closed frame
//
// One byte per cycle is taken while s_axis_tready is high; after the closing transfer a result
// passes through the snapshot register and then the result register before it leaves.
// Reset clears the byte count and both valid flags; the byte buffer is not reset.
// A stalled result register holds the snapshot stage; once that stage is full as well,
// every input transfer waits until the result transfers.
`default_nettype none

module laser_command_frame_decoder
	import lcfd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [7:0]          s_axis_tdata,  // [7:0] cmd_byte
	input  wire logic                s_axis_tlast,
	input  wire logic [0:0]          s_axis_tuser,  // [0] empty_frame
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// [3:0] kind, [6:4] flags, [8:7] laser_number, [46:9] x_value, [84:47] y_value,
	// [92:85] layer_index, [129:93] amount, [137:130] red, [145:138] green,
	// [153:146] blue, [154] air_blower, [159:155] zero
	output logic [OutDataW-1:0]      m_axis_tdata
);

	logic    valid_s1;
	logic    take_s1;
	snap_t   snap_s1;
	result_t result_q;

	lcfd_capture u_capture (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.in_empty (s_axis_tuser[0]),
		.take_s1  (take_s1),
		.in_ready (s_axis_tready),
		.valid_s1 (valid_s1),
		.snap_s1  (snap_s1)
	);

	lcfd_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.snap_s1     (snap_s1),
		.out_ready   (m_axis_tready),
		.take_s1     (take_s1),
		.out_valid_q (m_axis_tvalid),
		.result_q    (result_q)
	);

	assign m_axis_tdata = {5'b00000, result_q.air_blower, result_q.blue, result_q.green,
		result_q.red, result_q.amount, result_q.layer_index, result_q.y_value,
		result_q.x_value, result_q.laser_number, result_q.flags, result_q.kind};

	a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3:0] == KIND_EMPTY |-> m_axis_tdata[159:4] == '0)
		else $error("empty command carries nonzero fields");

	a_bad_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[3:0] == KIND_INCOMPLETE ||
		m_axis_tdata[3:0] == KIND_UNKNOWN) |-> m_axis_tdata[159:4] == '0)
		else $error("incomplete or unknown command carries nonzero fields");

	a_laser_only_power: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8:7] != 2'd0 |->
		m_axis_tdata[3:0] == KIND_POWER || m_axis_tdata[3:0] == KIND_LAYERPOWER)
		else $error("laser number set on non-power command");

endmodule

`default_nettype wire
